>>> hw/rtl/rcog_pkg.sv
// Shared types, codes and helpers for the ray-cast occupancy grid core.
// No dependencies; the top level, front end and back end import this package.
package rcog_pkg;

  localparam int unsigned CoordBits = 8;
  localparam int unsigned SizeBits  = 9;
  localparam int unsigned OutBits   = 16;

  // opcodes; code 3 is unused and falls into default arms
  localparam logic [1:0] OP_RAY   = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] CLASS_UNKNOWN  = 2'd0;
  localparam logic [1:0] CLASS_OCCUPIED = 2'd1;
  localparam logic [1:0] CLASS_FREE     = 2'd2;

  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  typedef struct packed {
    logic [SizeBits-1:0] grid_width;
    logic [SizeBits-1:0] grid_height;
  } cfg_t;

  typedef struct packed {
    logic [1:0]           op;
    logic [CoordBits-1:0] sensor_col;
    logic [CoordBits-1:0] sensor_row;
    logic [CoordBits-1:0] target_col;
    logic [CoordBits-1:0] target_row;
    logic                 in_range;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         cell_class;
    logic [OutBits-1:0] occupied_count;
    logic [OutBits-1:0] pass_count;
    logic               in_range;
  } res_t;

  typedef enum logic [2:0] {
    ST_WIPE,
    ST_IDLE,
    ST_WALK,
    ST_ANSWER,
    ST_RESP
  } state_e;

  // col < min(width, max_cols) splits into two compares since col < 256
  function automatic logic cell_ok(logic [CoordBits-1:0] col, logic [CoordBits-1:0] row,
                                   cfg_t cfg, int unsigned max_cols,
                                   int unsigned max_rows);
    return ({1'b0, col} < cfg.grid_width) && (32'(col) < max_cols) &&
           ({1'b0, row} < cfg.grid_height) && (32'(row) < max_rows);
  endfunction

  function automatic logic [31:0] cell_addr(logic [CoordBits-1:0] col,
                                            logic [CoordBits-1:0] row,
                                            int unsigned max_cols);
    return 32'(row) * max_cols + 32'(col);
  endfunction

endpackage

>>> hw/rtl/ray_cast_occupancy_grid_core.sv
// Top level of the ray-cast occupancy grid: front end, command queue,
// back end and result queue. Depends on rcog_pkg and all rcog_* modules.
//
//   channel   handshake           payload
//   -------   -----------------   -----------------------------------------------
//   input     push / full         opcode, sensor_col/row, target_col/row
//   result    pop / empty         cell_class, occupied_count, pass_count, in_range
//   config    cfg_we_i            cfg_idx_i, cfg_wdata_i (no wait, no read-back)
//
// A ray does one pass count read-modify-write per line cell inside the grid,
// overlapped one cell a cycle on the pass RAM. Query and clear items read both
// stores and answer from ST_ANSWER; out-of-range queries and clears answer from ST_RESP.
// After reset both RAMs are wiped over all MAX_COLS*MAX_ROWS cells (65536 by
// default); full stays high until then. Each side stalls alone behind its 2-beat queue.
module ray_cast_occupancy_grid_core
  import rcog_pkg::*;
#(
  parameter int unsigned MAX_COLS   = 256,
  parameter int unsigned MAX_ROWS   = 256,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [SizeBits-1:0]  cfg_wdata_i,
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           opcode_i,
  input  logic [CoordBits-1:0] sensor_col_i,
  input  logic [CoordBits-1:0] sensor_row_i,
  input  logic [CoordBits-1:0] target_col_i,
  input  logic [CoordBits-1:0] target_row_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [1:0]           cell_class_o,
  output logic [OutBits-1:0]   occupied_count_o,
  output logic [OutBits-1:0]   pass_count_o,
  output logic                 in_range_o
);

  localparam int unsigned CmdDepth = 2;
  localparam int unsigned ResDepth = 2;

  cfg_t cfg;
  cmd_t cmd_in, cmd_out;
  res_t res_in, res_out;
  logic cmd_push, cmd_full, cmd_empty, cmd_pop;
  logic res_push, res_full;
  logic wiping;

  rcog_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push_i       (push),
    .full_o       (full),
    .opcode_i     (opcode_i),
    .sensor_col_i (sensor_col_i),
    .sensor_row_i (sensor_row_i),
    .target_col_i (target_col_i),
    .target_row_i (target_row_i),
    .q_full_i     (cmd_full),
    .wiping_i     (wiping),
    .q_push_o     (cmd_push),
    .cmd_o        (cmd_in),
    .cfg_o        (cfg)
  );

  rcog_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(CmdDepth)) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_out),
    .empty_o (cmd_empty)
  );

  rcog_back #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .wiping_o    (wiping)
  );

  rcog_fifo #(.WIDTH($bits(res_t)), .DEPTH(ResDepth)) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign cell_class_o     = res_out.cell_class;
  assign occupied_count_o = res_out.occupied_count;
  assign pass_count_o     = res_out.pass_count;
  assign in_range_o       = res_out.in_range;

endmodule

>>> hw/rtl/rcog_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for both count stores.
module rcog_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/rcog_fifo.sv
// Small register queue for command and result beats.
// Standalone; instanced twice by the top level.
module rcog_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = slot_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("queue fill beyond depth");

  a_push_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue fill did not grow on push");

  a_pop_shrinks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> count_q == $past(count_q) - 1'b1)
    else $error("queue fill did not shrink on pop");

endmodule

>>> hw/rtl/rcog_front.sv
// Front end: grid size registers, input acceptance and range check.
// Depends on rcog_pkg; feeds the command queue.
module rcog_front
  import rcog_pkg::*;
#(
  parameter int unsigned MAX_COLS = 256,
  parameter int unsigned MAX_ROWS = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [SizeBits-1:0]  cfg_wdata_i,
  input  logic                 push_i,
  output logic                 full_o,
  input  logic [1:0]           opcode_i,
  input  logic [CoordBits-1:0] sensor_col_i,
  input  logic [CoordBits-1:0] sensor_row_i,
  input  logic [CoordBits-1:0] target_col_i,
  input  logic [CoordBits-1:0] target_row_i,
  input  logic                 q_full_i,
  input  logic                 wiping_i,
  output logic                 q_push_o,
  output cmd_t                 cmd_o,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic op_known;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GRID_WIDTH:  cfg_d.grid_width  = cfg_wdata_i;
        REG_GRID_HEIGHT: cfg_d.grid_height = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_width  <= SizeBits'(256);
      cfg_q.grid_height <= SizeBits'(256);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign op_known = (opcode_i == OP_RAY) || (opcode_i == OP_QUERY) || (opcode_i == OP_CLEAR);

  // no beat taken while the stores are being wiped
  assign full_o   = q_full_i || wiping_i;
  assign q_push_o = push_i && !full_o;
  assign cfg_o    = cfg_q;

  always_comb begin
    cmd_o.op         = opcode_i;
    cmd_o.sensor_col = sensor_col_i;
    cmd_o.sensor_row = sensor_row_i;
    cmd_o.target_col = target_col_i;
    cmd_o.target_row = target_row_i;
    cmd_o.in_range   = op_known &&
                       cell_ok(target_col_i, target_row_i, cfg_q, MAX_COLS, MAX_ROWS);
  end

endmodule

>>> hw/rtl/rcog_back.sv
// Back end: count stores, post-reset wipe, line walker and query/clear.
// Depends on rcog_pkg and rcog_ram; reads the command queue, fills the result queue.
module rcog_back
  import rcog_pkg::*;
#(
  parameter int unsigned MAX_COLS   = 256,
  parameter int unsigned MAX_ROWS   = 256,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  input  logic res_full_i,
  output logic res_push_o,
  output res_t res_o,
  output logic wiping_o
);

  localparam int unsigned Cells = MAX_COLS * MAX_ROWS;
  localparam int unsigned AW    = $clog2(Cells);

  state_e state_q, state_d;
  logic [AW-1:0]  wipe_addr_q, wipe_addr_d;
  cmd_t           cur_q, cur_d;
  logic [AW-1:0]  tgt_addr_q, tgt_addr_d;
  logic [CoordBits-1:0] x_q, x_d, y_q, y_d;
  logic           x_inc_q, x_inc_d, y_inc_q, y_inc_d;
  logic signed [10:0] dx_q, dx_d, dy_q, dy_d, err_q, err_d;
  logic signed [11:0] e2;
  logic           occ_pend_q, occ_pend_d, pass_pend_q, pass_pend_d;
  logic [AW-1:0]  pass_wa_q, pass_wa_d;

  logic                  occ_we, occ_re, pass_we, pass_re;
  logic [AW-1:0]         occ_waddr, occ_raddr, pass_waddr, pass_raddr;
  logic [COUNT_BITS-1:0] occ_wdata, occ_rdata, pass_wdata, pass_rdata;
  logic [COUNT_BITS-1:0] occ_inc, pass_inc;

  logic [AW-1:0] cmd_addr, walk_addr;
  logic          walk_ok, at_end;
  logic [CoordBits-1:0] adx, ady;

  rcog_ram #(.WIDTH(COUNT_BITS), .DEPTH(Cells)) u_occ_ram (
    .clk_i   (clk_i),
    .we_i    (occ_we),
    .waddr_i (occ_waddr),
    .wdata_i (occ_wdata),
    .re_i    (occ_re),
    .raddr_i (occ_raddr),
    .rdata_o (occ_rdata)
  );

  rcog_ram #(.WIDTH(COUNT_BITS), .DEPTH(Cells)) u_pass_ram (
    .clk_i   (clk_i),
    .we_i    (pass_we),
    .waddr_i (pass_waddr),
    .wdata_i (pass_wdata),
    .re_i    (pass_re),
    .raddr_i (pass_raddr),
    .rdata_o (pass_rdata)
  );

  assign cmd_addr  = AW'(cell_addr(cmd_i.target_col, cmd_i.target_row, MAX_COLS));
  assign walk_addr = AW'(cell_addr(x_q, y_q, MAX_COLS));
  assign walk_ok   = cell_ok(x_q, y_q, cfg_i, MAX_COLS, MAX_ROWS);
  assign at_end    = (x_q == cur_q.target_col) && (y_q == cur_q.target_row);
  assign occ_inc   = (occ_rdata == '1) ? occ_rdata : occ_rdata + 1'b1;
  assign pass_inc  = (pass_rdata == '1) ? pass_rdata : pass_rdata + 1'b1;
  assign adx = (cmd_i.target_col > cmd_i.sensor_col) ? cmd_i.target_col - cmd_i.sensor_col
                                                     : cmd_i.sensor_col - cmd_i.target_col;
  assign ady = (cmd_i.target_row > cmd_i.sensor_row) ? cmd_i.target_row - cmd_i.sensor_row
                                                     : cmd_i.sensor_row - cmd_i.target_row;
  assign e2       = {err_q, 1'b0};
  assign wiping_o = (state_q == ST_WIPE);

  always_comb begin
    state_d     = state_q;
    wipe_addr_d = wipe_addr_q;
    cur_d       = cur_q;
    tgt_addr_d  = tgt_addr_q;
    x_d         = x_q;
    y_d         = y_q;
    x_inc_d     = x_inc_q;
    y_inc_d     = y_inc_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    err_d       = err_q;
    occ_pend_d  = 1'b0;
    pass_pend_d = 1'b0;
    pass_wa_d   = pass_wa_q;
    cmd_pop_o   = 1'b0;
    res_push_o  = 1'b0;
    res_o       = '0;
    occ_re      = 1'b0;
    occ_raddr   = cmd_addr;
    pass_re     = 1'b0;
    pass_raddr  = cmd_addr;
    // read-modify-write completes in the cycle after its read
    occ_we      = occ_pend_q;
    occ_waddr   = tgt_addr_q;
    occ_wdata   = occ_inc;
    pass_we     = pass_pend_q;
    pass_waddr  = pass_wa_q;
    pass_wdata  = pass_inc;

    unique case (state_q)
      ST_WIPE: begin
        occ_we      = 1'b1;
        occ_waddr   = wipe_addr_q;
        occ_wdata   = '0;
        pass_we     = 1'b1;
        pass_waddr  = wipe_addr_q;
        pass_wdata  = '0;
        wipe_addr_d = wipe_addr_q + 1'b1;
        if (wipe_addr_q == AW'(Cells - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // result slot is reserved here: only this unit fills the result queue
        if (cmd_valid_i && !res_full_i) begin
          cmd_pop_o  = 1'b1;
          cur_d      = cmd_i;
          tgt_addr_d = cmd_addr;
          x_d        = cmd_i.sensor_col;
          y_d        = cmd_i.sensor_row;
          x_inc_d    = cmd_i.sensor_col < cmd_i.target_col;
          y_inc_d    = cmd_i.sensor_row < cmd_i.target_row;
          dx_d       = 11'(adx);
          dy_d       = -11'(ady);
          err_d      = 11'(adx) - 11'(ady);
          unique case (cmd_i.op) inside
            OP_RAY: begin
              state_d = ST_WALK;
              if (cmd_i.in_range) begin
                occ_re     = 1'b1;
                occ_pend_d = 1'b1;
              end
            end
            OP_QUERY, OP_CLEAR: begin
              if (cmd_i.in_range) begin
                occ_re  = 1'b1;
                pass_re = 1'b1;
                state_d = ST_ANSWER;
              end else begin
                state_d = ST_RESP;
              end
            end
            default: state_d = ST_RESP;
          endcase
        end
      end
      ST_WALK: begin
        if (walk_ok) begin
          pass_re     = 1'b1;
          pass_raddr  = walk_addr;
          pass_pend_d = 1'b1;
          pass_wa_d   = walk_addr;
        end
        if (at_end) begin
          state_d = ST_RESP;
        end else begin
          err_d = err_q + ((e2 > 12'(dy_q)) ? dy_q : 11'sd0)
                        + ((e2 < 12'(dx_q)) ? dx_q : 11'sd0);
          if (e2 > 12'(dy_q)) begin
            x_d = x_inc_q ? x_q + 1'b1 : x_q - 1'b1;
          end
          if (e2 < 12'(dx_q)) begin
            y_d = y_inc_q ? y_q + 1'b1 : y_q - 1'b1;
          end
        end
      end
      ST_ANSWER: begin
        res_push_o           = 1'b1;
        res_o.occupied_count = OutBits'(occ_rdata);
        res_o.pass_count     = OutBits'(pass_rdata);
        res_o.in_range       = 1'b1;
        if (cur_q.op == OP_QUERY) begin
          if (pass_rdata == '0) begin
            res_o.cell_class = CLASS_UNKNOWN;
          end else if ({occ_rdata, 1'b0} > {1'b0, pass_rdata}) begin
            res_o.cell_class = CLASS_OCCUPIED;
          end else begin
            res_o.cell_class = CLASS_FREE;
          end
        end else begin
          occ_we     = 1'b1;
          occ_waddr  = tgt_addr_q;
          occ_wdata  = '0;
          pass_we    = 1'b1;
          pass_waddr = tgt_addr_q;
          pass_wdata = '0;
        end
        state_d = ST_IDLE;
      end
      ST_RESP: begin
        res_push_o     = 1'b1;
        res_o.in_range = cur_q.in_range;
        state_d        = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_WIPE;
      wipe_addr_q <= '0;
      occ_pend_q  <= 1'b0;
      pass_pend_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wipe_addr_q <= wipe_addr_d;
      occ_pend_q  <= occ_pend_d;
      pass_pend_q <= pass_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    tgt_addr_q <= tgt_addr_d;
    x_q        <= x_d;
    y_q        <= y_d;
    x_inc_q    <= x_inc_d;
    y_inc_q    <= y_inc_d;
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    err_q      <= err_d;
    pass_wa_q  <= pass_wa_d;
  end

  a_res_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result beat pushed into a full queue");

  a_pass_rmw : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pass_pend_q |-> $past(pass_re))
    else $error("pass count write without a preceding read");

  a_walk_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && at_end) |=> state_q == ST_RESP)
    else $error("walk did not finish at the end-point cell");

  a_dual_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_we && pass_we) |-> (state_q == ST_WIPE || state_q == ST_ANSWER))
    else $error("both stores written outside wipe or clear");

endmodule
